[hw/rtl/rqbv_pkg.sv]
// ----------------------------------------------------------------------------
// rqbv_pkg
// Shared types and codes for the vector-pair to rotation quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rqbv_pkg;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_PARALLEL = 2'd1;
	localparam status_t STATUS_ZERO     = 2'd2;

	// special-case flags that ride along the pipeline
	typedef struct packed {
		logic zero_len;
		logic parallel;
	} flags_t;

	// Q30 one and output field limits
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [14:0] VEC_MAX  = 15'h7fff;

endpackage

`default_nettype wire

[hw/rtl/rotation_quaternion_between_vectors_top.sv]
// Throughput: one beat per cycle while the output buffer has room; the
// datapath is fully pipelined with bit-per-stage square root and divider
// units and a shared stall enable.
// A two-entry output buffer keeps the input side open while one result waits.
// Reset: arst_n clears all valid bits and the output buffer count; no other state.
// ----------------------------------------------------------------------------
// rotation_quaternion_between_vectors_top
// Rotation quaternion through the acute angle between two integer 3-vectors,
// fixed point output with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_quaternion_between_vectors_top #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// from_x, from_y, from_z, to_x, to_y, to_z (16 bits each)
	input  wire logic [95:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_scalar[62:48],
	// status[64:63], zero fill[71:65]
	output logic [71:0]      m_tdata
);

	localparam int SH     = 30 - FRAC_BITS;
	localparam int VDEN_W = 32 + SH;
	localparam int VQ_W   = 15;
	localparam int VNUM_W = VDEN_W + VQ_W;
	localparam int CW     = ((VNUM_W > 64) ? VNUM_W : 64) + 1;
	localparam logic [32:0] HALF = (SH == 0) ? 33'd0 : (33'd1 << (SH - 1));
	localparam logic [32:0] SCAL_MAX = (FRAC_BITS >= 15) ? 33'd32767
		: ((33'd1 << FRAC_BITS) - 33'd1);
	localparam int SA_W = 2 + 3 + 32 + 96;
	localparam int SV_W = 2 + 3 + 3 + 15;

	logic en;
	logic push;
	logic pop;
	logic [1:0] count_q;

	// global stall: pipeline moves while the output buffer has room
	assign en       = (count_q != 2'd2);
	assign s_tready = en;

	// input fields
	logic signed [15:0] ax, ay, az, bx, by, bz;
	assign ax = s_tdata[15:0];
	assign ay = s_tdata[31:16];
	assign az = s_tdata[47:32];
	assign bx = s_tdata[63:48];
	assign by = s_tdata[79:64];
	assign bz = s_tdata[95:80];

	// stage 1: all 16x16 products
	logic v_s1;
	logic signed [31:0] aa_s1 [3];
	logic signed [31:0] bb_s1 [3];
	logic signed [31:0] ab_s1 [3];
	logic signed [31:0] cp_s1 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1[0] <= ax * ax;
			aa_s1[1] <= ay * ay;
			aa_s1[2] <= az * az;
			bb_s1[0] <= bx * bx;
			bb_s1[1] <= by * by;
			bb_s1[2] <= bz * bz;
			ab_s1[0] <= ax * bx;
			ab_s1[1] <= ay * by;
			ab_s1[2] <= az * bz;
			cp_s1[0] <= ay * bz;
			cp_s1[1] <= az * by;
			cp_s1[2] <= az * bx;
			cp_s1[3] <= ax * bz;
			cp_s1[4] <= ax * by;
			cp_s1[5] <= ay * bx;
		end
	end

	// stage 2: squared lengths, dot and cross products
	logic v_s2;
	logic [31:0] asq_s2, bsq_s2;
	logic signed [33:0] dot_s2;
	logic signed [32:0] x_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			asq_s2 <= $unsigned(aa_s1[0]) + $unsigned(aa_s1[1]) + $unsigned(aa_s1[2]);
			bsq_s2 <= $unsigned(bb_s1[0]) + $unsigned(bb_s1[1]) + $unsigned(bb_s1[2]);
			dot_s2 <= 34'(ab_s1[0]) + 34'(ab_s1[1]) + 34'(ab_s1[2]);
			x_s2[0] <= 33'(cp_s1[0]) - 33'(cp_s1[1]);
			x_s2[1] <= 33'(cp_s1[2]) - 33'(cp_s1[3]);
			x_s2[2] <= 33'(cp_s1[4]) - 33'(cp_s1[5]);
		end
	end

	// stage 3: magnitudes, flags, A*B and squared cross components
	logic v_s3;
	rqbv_pkg::flags_t flg_s3;
	logic [2:0]  sgn_s3;
	logic [31:0] dmag_s3;
	logic [31:0] m_s3 [3];
	logic [63:0] abp_s3;
	logic [63:0] msq_s3 [3];
	logic [33:0] dneg;
	logic [32:0] xneg [3];
	logic [31:0] dmag_c;
	logic [31:0] m_c [3];

	always_comb begin
		dneg   = -dot_s2;
		dmag_c = dot_s2[33] ? dneg[31:0] : dot_s2[31:0];
		for (int i = 0; i < 3; i++) begin
			xneg[i] = -x_s2[i];
			m_c[i]  = x_s2[i][32] ? xneg[i][31:0] : x_s2[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s3.zero_len <= (asq_s2 == 32'd0) || (bsq_s2 == 32'd0);
			flg_s3.parallel <= (x_s2[0] == 33'sd0) && (x_s2[1] == 33'sd0)
				&& (x_s2[2] == 33'sd0);
			sgn_s3  <= {x_s2[2][32], x_s2[1][32], x_s2[0][32]};
			dmag_s3 <= dmag_c;
			abp_s3  <= 64'(asq_s2) * 64'(bsq_s2);
			for (int i = 0; i < 3; i++) begin
				m_s3[i]   <= m_c[i];
				msq_s3[i] <= 64'(m_c[i]) * 64'(m_c[i]);
			end
		end
	end

	// stage 4: squared cross length
	logic v_s4;
	logic [63:0] abp_s4, xsq_s4;
	logic [SA_W-1:0] sa_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abp_s4 <= abp_s3;
			xsq_s4 <= msq_s3[0] + msq_s3[1] + msq_s3[2];
			sa_s4  <= {flg_s3, sgn_s3, dmag_s3, m_s3[2], m_s3[1], m_s3[0]};
		end
	end

	// roots of A*B and of the squared cross length
	logic                  va;
	logic [1:0][31:0]      roots_a;
	logic [SA_W-1:0]       sa_a;

	rqbv_isqrt #(
		.LANES  (2),
		.IN_W   (64),
		.SIDE_W (SA_W)
	) u_sqrt_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rad       ({xsq_s4, abp_s4}),
		.side_in   (sa_s4),
		.out_valid (va),
		.root      (roots_a),
		.side_out  (sa_a)
	);

	// cosine in Q30: |d| * 2^30 / R
	logic [SA_W-1:0]  sc_in;
	logic             vc;
	logic [0:0][30:0] c_raw;
	logic [SA_W-1:0]  sc;

	assign sc_in = {sa_a[SA_W-1:SA_W-5], sa_a[95:0], roots_a[1]};

	rqbv_div #(
		.LANES  (1),
		.DEN_W  (32),
		.Q_W    (31),
		.SIDE_W (SA_W)
	) u_div_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (va),
		.num       (63'({sa_a[127:96], 30'd0})),
		.den       (roots_a[0]),
		.side_in   (sc_in),
		.out_valid (vc),
		.quo       (c_raw),
		.side_out  (sc)
	);

	// stage 5: clamp the cosine and form the half-angle radicands
	logic v_s5;
	logic [61:0] sarg_s5, targ_s5;
	logic [SA_W-1:0] sc_s5;
	logic [30:0] c30;
	logic [31:0] csum, cdif;

	always_comb begin
		c30  = (c_raw[0] > rqbv_pkg::Q30_ONE) ? rqbv_pkg::Q30_ONE : c_raw[0];
		csum = 32'(rqbv_pkg::Q30_ONE) + 32'(c30);
		cdif = 32'(rqbv_pkg::Q30_ONE) - 32'(c30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= vc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sarg_s5 <= 62'(csum) << 29;
			targ_s5 <= 62'(cdif) << 29;
			sc_s5   <= sc;
		end
	end

	// half-angle cosine and sine in Q30
	logic             vb;
	logic [1:0][30:0] roots_b;
	logic [SA_W-1:0]  sb;

	rqbv_isqrt #(
		.LANES  (2),
		.IN_W   (62),
		.SIDE_W (SA_W)
	) u_sqrt_half (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.rad       ({targ_s5, sarg_s5}),
		.side_in   (sc_s5),
		.out_valid (vb),
		.root      (roots_b),
		.side_out  (sb)
	);

	// stage 6: scale cross components by the half-angle sine, round the scalar
	logic v_s6;
	logic [62:0] prod_s6 [3];
	logic [VDEN_W-1:0] den_s6;
	logic [14:0] scal_s6;
	logic [4:0] fs_s6;
	logic [32:0] scal_c;

	always_comb begin
		scal_c = (33'(roots_b[0]) + HALF) >> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= 63'(sb[32*i+32 +: 32]) * 63'(roots_b[1]);
			end
			den_s6  <= VDEN_W'(sb[31:0]) << SH;
			scal_s6 <= (scal_c > SCAL_MAX) ? SCAL_MAX[14:0] : scal_c[14:0];
			fs_s6   <= sb[SA_W-1:SA_W-5];
		end
	end

	// stage 7: add the rounding half and catch quotients past the field
	logic v_s7;
	logic [2:0][VNUM_W-1:0] num_s7;
	logic [VDEN_W-1:0] den_s7;
	logic [2:0] sat_s7;
	logic [14:0] scal_s7;
	logic [4:0] fs_s7;
	logic [63:0] numf [3];
	logic [CW-1:0] dlim;

	always_comb begin
		dlim = CW'(den_s6) << VQ_W;
		for (int i = 0; i < 3; i++) begin
			numf[i] = 64'(prod_s6[i]) + 64'(den_s6 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= VNUM_W'(numf[i]);
				sat_s7[i] <= CW'(numf[i]) >= dlim;
			end
			den_s7  <= den_s6;
			scal_s7 <= scal_s6;
			fs_s7   <= fs_s6;
		end
	end

	// vector part quotients
	logic                     vv;
	logic [2:0][VQ_W-1:0]     qv;
	logic [SV_W-1:0]          sv;

	rqbv_div #(
		.LANES  (3),
		.DEN_W  (VDEN_W),
		.Q_W    (VQ_W),
		.SIDE_W (SV_W)
	) u_div_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (num_s7),
		.den       ({den_s7, den_s7, den_s7}),
		.side_in   ({fs_s7, sat_s7, scal_s7}),
		.out_valid (vv),
		.quo       (qv),
		.side_out  (sv)
	);

	// final assembly: saturate, apply sign, special cases
	rqbv_pkg::flags_t  fflg;
	logic [2:0]        fsgn;
	logic [2:0]        fsat;
	logic [15:0]       qval [3];
	rqbv_pkg::status_t fstat;
	logic [64:0]       res;

	always_comb begin
		fflg = rqbv_pkg::flags_t'(sv[SV_W-1:SV_W-2]);
		fsgn = sv[20:18];
		fsat = sv[17:15];
		if (fflg.zero_len) begin
			fstat = rqbv_pkg::STATUS_ZERO;
		end else if (fflg.parallel) begin
			fstat = rqbv_pkg::STATUS_PARALLEL;
		end else begin
			fstat = rqbv_pkg::STATUS_OK;
		end
		for (int i = 0; i < 3; i++) begin
			qval[i] = {1'b0, fsat[i] ? rqbv_pkg::VEC_MAX : qv[i]};
			if (fsgn[i]) begin
				qval[i] = -qval[i];
			end
		end
		if (fstat == rqbv_pkg::STATUS_OK) begin
			res = {fstat, sv[14:0], qval[2], qval[1], qval[0]};
		end else begin
			res = {fstat, 63'd0};
		end
	end

	// output buffer, two entries
	logic [64:0] e0_q, e1_q;

	assign push = vv && en;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case (count_q)
				2'd0: begin
					if (push) count_q <= 2'd1;
				end
				2'd1: begin
					if (push && !pop) count_q <= 2'd2;
					else if (pop && !push) count_q <= 2'd0;
				end
				2'd2: begin
					if (pop) count_q <= 2'd1;
				end
				default: count_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (count_q)
			2'd0: begin
				if (push) e0_q <= res;
			end
			2'd1: begin
				if (push && pop) e0_q <= res;
				else if (push) e1_q <= res;
			end
			2'd2: begin
				if (pop) e0_q <= e1_q;
			end
			default: e0_q <= e0_q;
		endcase
	end

	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = {7'd0, e0_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[64:63] != rqbv_pkg::STATUS_OK) |-> (m_tdata[62:0] == 63'd0))
		else $error("special-case result carries nonzero quaternion");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[64:63] == rqbv_pkg::STATUS_OK)
			|| (m_tdata[64:63] == rqbv_pkg::STATUS_PARALLEL)
			|| (m_tdata[64:63] == rqbv_pkg::STATUS_ZERO))
		else $error("bad status code");

	a_scalar_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (33'(m_tdata[62:48]) <= SCAL_MAX))
		else $error("scalar part above its limit");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vv))
		else $error("pipeline advanced during stall");
`endif

endmodule

`default_nettype wire

[hw/rtl/rqbv_isqrt.sv]
// ----------------------------------------------------------------------------
// rqbv_isqrt
// Pipelined integer square root (floor), one result bit per stage, several
// lanes in lock step with a shared sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rqbv_isqrt #(
	parameter int LANES  = 2,
	parameter int IN_W   = 64,
	parameter int SIDE_W = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic [LANES-1:0][IN_W-1:0]        rad,
	input  wire logic [SIDE_W-1:0]                 side_in,
	output logic                                   out_valid,
	output logic [LANES-1:0][IN_W/2-1:0]           root,
	output logic [SIDE_W-1:0]                      side_out
);

	localparam int RW  = IN_W / 2;
	localparam int RMW = RW + 2;

	logic [RW:1]                   vld_s;
	logic [LANES-1:0][IN_W-1:0]    rad_s  [1:RW];
	logic [LANES-1:0][RMW-1:0]     rem_s  [1:RW];
	logic [LANES-1:0][RW-1:0]      root_s [1:RW];
	logic [SIDE_W-1:0]             side_s [1:RW];

	genvar k;
	generate
		for (k = 0; k < RW; k++) begin : g_step
			logic                          pv;
			logic [LANES-1:0][IN_W-1:0]    prad;
			logic [LANES-1:0][RMW-1:0]     prem;
			logic [LANES-1:0][RW-1:0]      proot;
			logic [SIDE_W-1:0]             pside;
			logic [LANES-1:0][RMW-1:0]     nrem;
			logic [LANES-1:0][RW-1:0]      nroot;

			// previous stage or input ports
			if (k == 0) begin : g_first
				assign pv    = in_valid;
				assign prad  = rad;
				assign prem  = '0;
				assign proot = '0;
				assign pside = side_in;
			end else begin : g_mid
				assign pv    = vld_s[k];
				assign prad  = rad_s[k];
				assign prem  = rem_s[k];
				assign proot = root_s[k];
				assign pside = side_s[k];
			end

			// one digit: bring down two bits, try subtracting 4*root+1
			always_comb begin
				logic [RMW-1:0] cur;
				logic [RMW-1:0] trial;
				for (int l = 0; l < LANES; l++) begin
					cur   = {prem[l][RMW-3:0], prad[l][IN_W-1 -: 2]};
					trial = {proot[l], 2'b01};
					if (cur >= trial) begin
						nrem[l]  = cur - trial;
						nroot[l] = {proot[l][RW-2:0], 1'b1};
					end else begin
						nrem[l]  = cur;
						nroot[l] = {proot[l][RW-2:0], 1'b0};
					end
				end
			end

			// stage registers
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[k+1] <= nroot;
					side_s[k+1] <= pside;
				end
			end

			if (k < RW - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k+1] <= nrem;
						for (int l = 0; l < LANES; l++) begin
							rad_s[k+1][l] <= prad[l] << 2;
						end
					end
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];

endmodule

`default_nettype wire

[hw/rtl/rqbv_div.sv]
// ----------------------------------------------------------------------------
// rqbv_div
// Pipelined restoring divider, one quotient bit per stage, several lanes in
// lock step with a shared sideband. The numerator must be below den << Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module rqbv_div #(
	parameter int LANES  = 1,
	parameter int DEN_W  = 32,
	parameter int Q_W    = 31,
	parameter int SIDE_W = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic [LANES-1:0][DEN_W+Q_W-1:0]   num,
	input  wire logic [LANES-1:0][DEN_W-1:0]       den,
	input  wire logic [SIDE_W-1:0]                 side_in,
	output logic                                   out_valid,
	output logic [LANES-1:0][Q_W-1:0]              quo,
	output logic [SIDE_W-1:0]                      side_out
);

	localparam int W = DEN_W + Q_W;

	logic [Q_W:1]                  vld_s;
	logic [LANES-1:0][W-1:0]       rem_s  [1:Q_W];
	logic [LANES-1:0][DEN_W-1:0]   den_s  [1:Q_W];
	logic [LANES-1:0][Q_W-1:0]     quo_s  [1:Q_W];
	logic [SIDE_W-1:0]             side_s [1:Q_W];

	genvar k;
	generate
		for (k = 0; k < Q_W; k++) begin : g_step
			logic                          pv;
			logic [LANES-1:0][W-1:0]       prem;
			logic [LANES-1:0][DEN_W-1:0]   pden;
			logic [LANES-1:0][Q_W-1:0]     pquo;
			logic [SIDE_W-1:0]             pside;
			logic [LANES-1:0][W-1:0]       nrem;
			logic [LANES-1:0][Q_W-1:0]     nquo;

			// previous stage or input ports
			if (k == 0) begin : g_first
				assign pv    = in_valid;
				assign prem  = num;
				assign pden  = den;
				assign pquo  = '0;
				assign pside = side_in;
			end else begin : g_mid
				assign pv    = vld_s[k];
				assign prem  = rem_s[k];
				assign pden  = den_s[k];
				assign pquo  = quo_s[k];
				assign pside = side_s[k];
			end

			// one quotient bit: compare against the shifted divisor
			always_comb begin
				logic [W-1:0] dsh;
				for (int l = 0; l < LANES; l++) begin
					dsh = W'(pden[l]) << (Q_W - 1 - k);
					if (prem[l] >= dsh) begin
						nrem[l] = prem[l] - dsh;
						nquo[l] = (pquo[l] << 1) | Q_W'(1);
					end else begin
						nrem[l] = prem[l];
						nquo[l] = pquo[l] << 1;
					end
				end
			end

			// stage registers
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					quo_s[k+1]  <= nquo;
					side_s[k+1] <= pside;
				end
			end

			if (k < Q_W - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k+1] <= nrem;
						den_s[k+1] <= pden;
					end
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[Q_W];
	assign quo       = quo_s[Q_W];
	assign side_out  = side_s[Q_W];

endmodule

`default_nettype wire

[dv/rqbv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqbv_checker
// Watches both stream channels of the quaternion pipeline, computes the
// expected quaternion for every accepted vector pair and compares each
// result beat, field by field, against the oldest pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module rqbv_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// from_x, from_y, from_z, to_x, to_y, to_z (16 bits each)
	input  wire logic [95:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// quat_x, quat_y, quat_z, quat_scalar, status, zero fill
	input  wire logic [71:0] m_tdata,
	output int               fail_count,
	output int               pending_count
);

	localparam int FRAC_BITS = 15;
	localparam int SHIFT     = 30 - FRAC_BITS;

	typedef struct packed {
		logic [15:0]       qx;
		logic [15:0]       qy;
		logic [15:0]       qz;
		logic [14:0]       scalar;
		rqbv_pkg::status_t st;
	} quat_t;

	quat_t quat_fifo[$];

	// floor square root on 64 bits
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned pw;
		r  = 0;
		pw = 64'h1 << 62;
		while (pw > v)
			pw >>= 2;
		while (pw != 0) begin
			if (v >= r + pw) begin
				v -= r + pw;
				r = (r >> 1) + pw;
			end else begin
				r >>= 1;
			end
			pw >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	// quaternion turning vector a into vector b through the acute angle
	function automatic quat_t rotation_quat(logic [95:0] d);
		longint          a[3], b[3], x[3];
		longint          dot;
		longint unsigned asq, bsq, xsq, dmag, r, c30, s30, t30, n, denom, q, sc;
		logic [15:0]     parts[3];
		quat_t           o;
		asq = 0;
		bsq = 0;
		xsq = 0;
		dot = 0;
		o   = '0;
		for (int k = 0; k < 3; k++) begin
			a[k] = longint'($signed(d[16*k +: 16]));
			b[k] = longint'($signed(d[16*(k+3) +: 16]));
			asq += a[k] * a[k];
			bsq += b[k] * b[k];
			dot += a[k] * b[k];
		end
		// zero-length input
		if (asq == 0 || bsq == 0) begin
			o.st = rqbv_pkg::STATUS_ZERO;
			return o;
		end
		x[0] = a[1] * b[2] - a[2] * b[1];
		x[1] = a[2] * b[0] - a[0] * b[2];
		x[2] = a[0] * b[1] - a[1] * b[0];
		// parallel or antiparallel
		if (x[0] == 0 && x[1] == 0 && x[2] == 0) begin
			o.st = rqbv_pkg::STATUS_PARALLEL;
			return o;
		end
		for (int k = 0; k < 3; k++)
			xsq += magnitude(x[k]) * magnitude(x[k]);
		dmag = magnitude(dot);
		r    = floor_sqrt(asq * bsq);
		c30  = (dmag << 30) / r;
		if (c30 > 64'(rqbv_pkg::Q30_ONE))
			c30 = 64'(rqbv_pkg::Q30_ONE);
		s30 = floor_sqrt((64'(rqbv_pkg::Q30_ONE) + c30) << 29);
		t30 = floor_sqrt((64'(rqbv_pkg::Q30_ONE) - c30) << 29);
		sc  = (s30 + ((64'h1 << SHIFT) >> 1)) >> SHIFT;
		if (sc > 64'd32767)
			sc = 64'd32767;
		n     = floor_sqrt(xsq);
		denom = n << SHIFT;
		for (int k = 0; k < 3; k++) begin
			q = (magnitude(x[k]) * t30 + (denom >> 1)) / denom;
			if (q > 64'(rqbv_pkg::VEC_MAX))
				q = 64'(rqbv_pkg::VEC_MAX);
			if (x[k] < 0)
				q = 64'd0 - q;
			parts[k] = q[15:0];
		end
		o.qx     = parts[0];
		o.qy     = parts[1];
		o.qz     = parts[2];
		o.scalar = sc[14:0];
		o.st     = rqbv_pkg::STATUS_OK;
		return o;
	endfunction

	assign pending_count = quat_fifo.size();

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		quat_t exp_q;
		if (!arst_n) begin
			fail_count <= 0;
			quat_fifo.delete();
		end else begin
			if (s_tvalid && s_tready)
				quat_fifo.push_back(rotation_quat(s_tdata));
			if (m_tvalid && m_tready) begin
				if (quat_fifo.size() == 0) begin
					$error("result beat with no pending vector pair: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_q = quat_fifo.pop_front();
					if (m_tdata[15:0] !== exp_q.qx ||
					    m_tdata[31:16] !== exp_q.qy ||
					    m_tdata[47:32] !== exp_q.qz ||
					    m_tdata[62:48] !== exp_q.scalar ||
					    m_tdata[64:63] !== exp_q.st ||
					    m_tdata[71:65] !== 7'd0) begin
						fail_count <= fail_count + 1;
						if (m_tdata[15:0] !== exp_q.qx)
							$error("quat_x expected %0d actual %0d",
								$signed(exp_q.qx), $signed(m_tdata[15:0]));
						if (m_tdata[31:16] !== exp_q.qy)
							$error("quat_y expected %0d actual %0d",
								$signed(exp_q.qy), $signed(m_tdata[31:16]));
						if (m_tdata[47:32] !== exp_q.qz)
							$error("quat_z expected %0d actual %0d",
								$signed(exp_q.qz), $signed(m_tdata[47:32]));
						if (m_tdata[62:48] !== exp_q.scalar)
							$error("quat_scalar expected %0d actual %0d",
								exp_q.scalar, m_tdata[62:48]);
						if (m_tdata[64:63] !== exp_q.st)
							$error("status expected %0d actual %0d",
								exp_q.st, m_tdata[64:63]);
						if (m_tdata[71:65] !== 7'd0)
							$error("zero fill expected 0 actual %h", m_tdata[71:65]);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives vector pairs into the quaternion pipeline in random bursts, with a
// directed opening of corner vectors, while the result side stalls on its own
// pattern and once holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int N_RANDOM = 800;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	int          fail_count;
	int          pending_count;
	int          burst_left;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rotation_quaternion_between_vectors_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rqbv_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	function automatic logic [95:0] pack_pair(int ax, int ay, int az, int bx, int by, int bz);
		return {16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
	endfunction

	// one beat on the input side; gaps come between bursts
	task automatic send_pair(logic [95:0] d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	function automatic int rand16();
		return $signed(16'($urandom()));
	endfunction

	// random pair, mostly general vectors, with parallel and near parallel sets
	function automatic logic [95:0] random_pair();
		int ax, ay, az, bx, by, bz, m;
		ax = rand16();
		ay = rand16();
		az = rand16();
		bx = rand16();
		by = rand16();
		bz = rand16();
		case ($urandom_range(0, 9))
			0: begin
				// small components
				ax = ax % 8; ay = ay % 8; az = az % 8;
				bx = bx % 8; by = by % 8; bz = bz % 8;
			end
			1: begin
				// scaled copy, parallel or antiparallel
				ax = ax % 128; ay = ay % 128; az = az % 128;
				m = $urandom_range(0, 1) ? $urandom_range(1, 200) : -$urandom_range(1, 200);
				bx = ax * m; by = ay * m; bz = az * m;
			end
			2: begin
				// nearly parallel
				bx = ax + $urandom_range(0, 2) - 1;
				by = ay;
				bz = az;
				if (bx > 32767) bx = 32766;
				if (bx < -32768) bx = -32767;
			end
			3: begin
				// one vector zero
				if ($urandom_range(0, 1)) begin
					ax = 0; ay = 0; az = 0;
				end else begin
					bx = 0; by = 0; bz = 0;
				end
			end
			default: ;
		endcase
		return pack_pair(ax, ay, az, bx, by, bz);
	endfunction

	// result side: changing stall pattern, with one long hold-off
	initial begin
		int cyc;
		int mode;
		m_tready <= 1'b0;
		cyc  = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (cyc >= 300 && cyc < 800)
				m_tready <= 1'b0;
			else
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
		end
	end

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [95:0] directed[$];
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			pack_pair(0, 0, 0, 1, 2, 3),
			pack_pair(5, -7, 9, 0, 0, 0),
			pack_pair(0, 0, 0, 0, 0, 0),
			pack_pair(3, 4, 5, 6, 8, 10),
			pack_pair(3, 4, 5, -3, -4, -5),
			pack_pair(-32768, -32768, -32768, 32767, 32767, 32767),
			pack_pair(-32768, -32768, -32768, -32768, -32768, -32768),
			pack_pair(32767, 32767, 32767, 32767, 32767, 32767),
			pack_pair(-32768, 32767, -32768, 32767, -32768, 32767),
			pack_pair(-32768, 0, 0, 0, -32768, 0),
			pack_pair(32767, 0, 0, 0, 0, 32767),
			pack_pair(1, 0, 0, 0, 1, 0),
			pack_pair(32767, 32767, 32767, 32766, 32767, 32767),
			pack_pair(32767, 1, 0, 32767, 0, 1),
			pack_pair(1, 1, 0, 1, -1, 0),
			pack_pair(-32768, -32768, 32767, 32767, -32768, -32768),
			pack_pair(-1, -1, -1, 1, 2, -3),
			pack_pair(1000, -2000, 3000, -1000, 2000, 2999),
			pack_pair(32767, -32768, 1, -32768, 32767, -1)
		};
		foreach (directed[i])
			send_pair(directed[i]);
		for (int i = 0; i < N_RANDOM; i++)
			send_pair(random_pair());
		s_tvalid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/rqbv_pkg.sv
hw/rtl/rqbv_isqrt.sv
hw/rtl/rqbv_div.sv
hw/rtl/rotation_quaternion_between_vectors_top.sv
dv/rqbv_checker.sv
dv/tb_top.sv
